// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape package
// Result codes and the result record types shared by the decoder, the result
// buffer and the top level.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned MaxResults = 6;

  // Status codes carried with each result transaction.
  localparam logic [2:0] ST_DATA       = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_EXP_QUOTE  = 3'd2;
  localparam logic [2:0] ST_BAD_UNI    = 3'd3;
  localparam logic [2:0] ST_BAD_ESC    = 3'd4;
  localparam logic [2:0] ST_UNTERM     = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] status;
  } jsu_ent_t;

  // All results caused by one input transaction, in emission order.
  typedef struct packed {
    logic [2:0]                     count;
    jsu_ent_t [MaxResults-1:0]      ent;
  } jsu_res_t;

endpackage

// ===== rtl/core/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the parser state and turns one text byte or end mark into the full
// list of result records it causes.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              mode,
  input  logic [7:0]        in_byte,
  output jsu_pkg::jsu_res_t res
);
  import jsu_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_STR  = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX  = 3'd3;
  localparam logic [2:0] PH_HIGH = 3'd4;
  localparam logic [2:0] PH_HB   = 3'd5;
  localparam logic [2:0] PH_HU   = 3'd6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_CR  = 8'h0D;
  localparam logic [7:0] CC_TAB = 8'h09;

  localparam logic [15:0] HIGH_LO = 16'hD800;
  localparam logic [15:0] HIGH_HI = 16'hDBFF;
  localparam logic [15:0] LOW_LO  = 16'hDC00;
  localparam logic [15:0] LOW_HI  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [9:0]  held_r, held_nxt;

  logic        is_hex;
  logic [3:0]  hex_val;
  logic [15:0] hv;
  logic [2:0]  eff;
  logic        flush;
  logic        one;
  logic        use_cp;
  logic [7:0]  one_data;
  logic [2:0]  one_status;
  logic [20:0] cp;
  jsu_ent_t    mn [4];
  logic [2:0]  m_cnt;
  jsu_ent_t    hb [3];

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
    hv = {accum_r[11:0], hex_val};
  end

  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    dcnt_nxt   = dcnt_r;
    held_nxt   = held_r;
    flush      = 1'b0;
    one        = 1'b0;
    use_cp     = 1'b0;
    one_data   = 8'd0;
    one_status = ST_DATA;
    cp         = 21'd0;
    eff        = phase_r;

    if (mode) begin
      one       = 1'b1;
      phase_nxt = PH_IDLE;
      accum_nxt = 16'd0;
      dcnt_nxt  = 2'd0;
      held_nxt  = 10'd0;
      case (phase_r)
        PH_IDLE: one_status = ST_EXP_QUOTE;
        PH_HEX:  one_status = ST_BAD_UNI;
        PH_HU: begin
          flush      = 1'b1;
          one_status = ST_BAD_UNI;
        end
        PH_HIGH, PH_HB: begin
          flush      = 1'b1;
          one_status = ST_UNTERM;
        end
        default: one_status = ST_UNTERM;
      endcase
    end else begin
      // An unpaired held surrogate is flushed, then the byte is taken as
      // ordinary string content or as an ordinary escape letter.
      if (phase_r == PH_HIGH && in_byte != CH_BSLASH) begin
        flush    = 1'b1;
        held_nxt = 10'd0;
        eff      = PH_STR;
      end else if (phase_r == PH_HB && in_byte != CH_U) begin
        flush    = 1'b1;
        held_nxt = 10'd0;
        eff      = PH_ESC;
      end

      case (eff)
        PH_IDLE: begin
          if (in_byte == CH_QUOTE) begin
            phase_nxt = PH_STR;
          end else begin
            one        = 1'b1;
            one_status = ST_EXP_QUOTE;
          end
        end
        PH_STR: begin
          if (in_byte == CH_QUOTE) begin
            one        = 1'b1;
            one_status = ST_DONE;
            phase_nxt  = PH_IDLE;
            accum_nxt  = 16'd0;
            dcnt_nxt   = 2'd0;
            held_nxt   = 10'd0;
          end else if (in_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            one       = 1'b1;
            one_data  = in_byte;
            phase_nxt = PH_STR;
          end
        end
        PH_ESC: begin
          one       = 1'b1;
          phase_nxt = PH_STR;
          case (in_byte)
            CH_QUOTE:  one_data = CH_QUOTE;
            CH_BSLASH: one_data = CH_BSLASH;
            CH_SLASH:  one_data = CH_SLASH;
            CH_B:      one_data = CC_BS;
            CH_F:      one_data = CC_FF;
            CH_N:      one_data = CC_LF;
            CH_R:      one_data = CC_CR;
            CH_T:      one_data = CC_TAB;
            CH_U: begin
              one       = 1'b0;
              accum_nxt = 16'd0;
              dcnt_nxt  = 2'd0;
              phase_nxt = PH_HEX;
            end
            default: begin
              one_status = ST_BAD_ESC;
              phase_nxt  = PH_IDLE;
              accum_nxt  = 16'd0;
              dcnt_nxt   = 2'd0;
              held_nxt   = 10'd0;
            end
          endcase
        end
        PH_HIGH: begin
          phase_nxt = PH_HB;
        end
        PH_HB: begin
          accum_nxt = 16'd0;
          dcnt_nxt  = 2'd0;
          phase_nxt = PH_HU;
        end
        PH_HEX, PH_HU: begin
          if (!is_hex) begin
            flush      = (eff == PH_HU);
            one        = 1'b1;
            one_status = ST_BAD_UNI;
            phase_nxt  = PH_IDLE;
            accum_nxt  = 16'd0;
            dcnt_nxt   = 2'd0;
            held_nxt   = 10'd0;
          end else if (dcnt_r != 2'd3) begin
            accum_nxt = hv;
            dcnt_nxt  = dcnt_r + 2'd1;
          end else begin
            accum_nxt = 16'd0;
            dcnt_nxt  = 2'd0;
            if (eff == PH_HU && hv >= LOW_LO && hv <= LOW_HI) begin
              cp        = SUPP_BASE + {1'b0, held_r, hv[9:0]};
              use_cp    = 1'b1;
              held_nxt  = 10'd0;
              phase_nxt = PH_STR;
            end else begin
              flush    = (eff == PH_HU);
              held_nxt = 10'd0;
              if (hv >= HIGH_LO && hv <= HIGH_HI) begin
                held_nxt  = hv[9:0];
                phase_nxt = PH_HIGH;
              end else begin
                cp        = {5'd0, hv};
                use_cp    = 1'b1;
                phase_nxt = PH_STR;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          accum_nxt = 16'd0;
          dcnt_nxt  = 2'd0;
          held_nxt  = 10'd0;
        end
      endcase
    end
  end

  // UTF-8 encoding of the main code point, or the single record.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mn[i] = '{data: 8'd0, status: ST_DATA};
    end
    m_cnt = 3'd0;
    if (one) begin
      mn[0] = '{data: one_data, status: one_status};
      m_cnt = 3'd1;
    end else if (use_cp) begin
      if (cp[20:7] == 14'd0) begin
        mn[0].data = {1'b0, cp[6:0]};
        m_cnt      = 3'd1;
      end else if (cp[20:11] == 10'd0) begin
        mn[0].data = {3'b110, cp[10:6]};
        mn[1].data = {2'b10, cp[5:0]};
        m_cnt      = 3'd2;
      end else if (cp[20:16] == 5'd0) begin
        mn[0].data = {4'b1110, cp[15:12]};
        mn[1].data = {2'b10, cp[11:6]};
        mn[2].data = {2'b10, cp[5:0]};
        m_cnt      = 3'd3;
      end else begin
        mn[0].data = {5'b11110, cp[20:18]};
        mn[1].data = {2'b10, cp[17:12]};
        mn[2].data = {2'b10, cp[11:6]};
        mn[3].data = {2'b10, cp[5:0]};
        m_cnt      = 3'd4;
      end
    end
  end

  // A held high surrogate always encodes as ED, A0|h[9:6], 80|h[5:0].
  always_comb begin
    hb[0] = '{data: 8'hED, status: ST_DATA};
    hb[1] = '{data: {4'b1010, held_r[9:6]}, status: ST_DATA};
    hb[2] = '{data: {2'b10, held_r[5:0]}, status: ST_DATA};
  end

  always_comb begin
    res.ent = '0;
    if (flush) begin
      for (int i = 0; i < 3; i++) begin
        res.ent[i]     = hb[i];
        res.ent[i + 3] = mn[i];
      end
      res.count = m_cnt + 3'd3;
    end else begin
      for (int i = 0; i < 4; i++) begin
        res.ent[i] = mn[i];
      end
      res.count = m_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      accum_r <= 16'd0;
      dcnt_r  <= 2'd0;
      held_r  <= 10'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      dcnt_r  <= dcnt_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== rtl/core/jsu_outq.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape result buffer
// Registers the results of one transaction and hands them out one per cycle while not stalled.
// ----------------------------------------------------------------------------
module jsu_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  jsu_pkg::jsu_res_t res,
  input  logic              out_stall,
  output logic              free,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic [2:0]        out_status,
  output logic              out_last
);
  import jsu_pkg::*;

  jsu_ent_t   ent_r [MaxResults];
  logic [2:0] cnt_r;
  logic [2:0] idx_r;
  logic       take;

  assign out_valid  = (cnt_r != 3'd0);
  assign out_last   = out_valid && (idx_r == cnt_r - 3'd1);
  assign out_byte   = ent_r[idx_r].data;
  assign out_status = ent_r[idx_r].status;
  assign take       = out_valid && !out_stall;
  assign free       = !out_valid || (take && out_last);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MaxResults; i++) begin
        ent_r[i] <= res.ent[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 3'd0;
    end else if (load) begin
      cnt_r <= res.count;
      idx_r <= 3'd0;
    end else if (take) begin
      if (out_last) begin
        cnt_r <= 3'd0;
        idx_r <= 3'd0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/core/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper with UTF-8 output
// Decodes one quoted JSON string per pass and emits its text as UTF-8 bytes.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_mode, in_byte) carries one text
// byte per transaction, or an end-of-text mark when in_mode is high. The
// result channel (out_valid, out_stall, out_byte, out_status, out_last)
// carries decoded bytes, a string-done mark or an error code; out_last marks
// the final result caused by one input transaction.
// The decoder is a single registered pass: the parser state and the input
// byte are decoded combinationally and all resulting records are written into
// a six-entry result buffer at the accepting edge, so the first result is
// presented the cycle after acceptance.
// Throughput is set by the result buffer: an input transaction producing k
// results (k from 1 to 6) holds it until all k are taken, and one producing
// none leaves it empty. With at most one result per byte and no stall, one
// byte is taken every cycle. A new transaction is accepted in the same cycle
// as the last result of the previous one is taken.
// Reset (rst_n low, synchronous) empties the buffer and returns the parser to
// waiting for an opening quote. While the receiver stalls, the presented
// result holds and in_stall stays high for as long as any result is waiting.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic       out_last
);
  import jsu_pkg::*;

  jsu_res_t res;
  logic     free;
  logic     acc;

  // The buffer is free when empty or when its last result leaves this cycle.
  assign in_stall = !free;
  assign acc      = in_valid && free;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .mode    (in_mode),
    .in_byte (in_byte),
    .res     (res)
  );

  jsu_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (acc),
    .res        (res),
    .out_stall  (out_stall),
    .free       (free),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  // A status other than data always ends the results of its transaction.
  a_status_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DATA) |-> out_last)
    else $error("non-data status without last");

  // Non-data results carry a zero byte.
  a_status_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DATA) |-> (out_byte == 8'd0))
    else $error("non-data status with nonzero byte");

  // An empty result side never holds back the input side.
  a_no_idle_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while no result pending");

  // A result that is not the last one leaves the input stalled.
  a_multi_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("input taken while results still pending");

endmodule

// ===== tb/json_string_unescape_utf8_check.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper result checker
// Watches both channels of the unescaper. It decodes every accepted input
// transaction with its own copy of the parser state and compares each result
// transaction, field by field, with the oldest predicted result still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_string_unescape_utf8_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic [2:0] out_status,
  input  logic       out_last,
  output int         items_seen,
  output int         results_seen,
  output int         strings_closed,
  output int         errors_seen,
  output int         outstanding,
  output int         failures
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam int unsigned ReportLimit = 10;

  typedef enum logic [2:0] {
    WAIT_QUOTE,
    IN_TEXT,
    AFTER_BSL,
    UNI_DIGITS,
    HIGH_HELD,
    HIGH_BSL,
    HIGH_DIGITS
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } utf8_result_t;

  scan_phase_e  phase_q = WAIT_QUOTE;
  logic [15:0]  hex_acc = '0;
  logic [1:0]   digit_cnt = '0;
  logic [9:0]   held_hi = '0;
  utf8_result_t step_q[$];
  utf8_result_t due_q[$];
  int           item_n, result_n, closed_n, error_n, fail_n;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic emit(input logic [7:0] d, input logic [2:0] st);
    utf8_result_t r;
    r.data = d;
    r.status = st;
    r.last = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], ST_DATA);
    end else if (cp < 21'h800) begin
      emit(8'hC0 | cp[10:6], ST_DATA);
      emit(8'h80 | cp[5:0], ST_DATA);
    end else if (cp < 21'h10000) begin
      emit(8'hE0 | cp[15:12], ST_DATA);
      emit(8'h80 | cp[11:6], ST_DATA);
      emit(8'h80 | cp[5:0], ST_DATA);
    end else begin
      emit(8'hF0 | cp[20:18], ST_DATA);
      emit(8'h80 | cp[17:12], ST_DATA);
      emit(8'h80 | cp[11:6], ST_DATA);
      emit(8'h80 | cp[5:0], ST_DATA);
    end
  endtask

  task automatic return_idle();
    phase_q = WAIT_QUOTE;
    hex_acc = '0;
    digit_cnt = '0;
    held_hi = '0;
  endtask

  task automatic report_error(input logic [2:0] st);
    emit(8'h00, st);
    return_idle();
  endtask

  // An unpaired high surrogate goes out as its own three-byte sequence.
  task automatic release_held();
    emit_code_point({5'b0, 16'hD800 + {6'b0, held_hi}});
    held_hi = '0;
  endtask

  task automatic text_byte(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      emit(8'h00, ST_DONE);
      return_idle();
    end else if (c == CH_BSL) begin
      phase_q = AFTER_BSL;
    end else begin
      emit(c, ST_DATA);
      phase_q = IN_TEXT;
    end
  endtask

  task automatic escape_letter(input logic [7:0] e);
    logic [7:0] v;
    case (e)
      CH_QUOTE, CH_BSL, "/": v = e;
      "b": v = 8'h08;
      "f": v = 8'h0C;
      "n": v = 8'h0A;
      "r": v = 8'h0D;
      "t": v = 8'h09;
      "u": begin
        hex_acc = '0;
        digit_cnt = '0;
        phase_q = UNI_DIGITS;
        return;
      end
      default: begin
        report_error(ST_BAD_ESC);
        return;
      end
    endcase
    emit(v, ST_DATA);
    phase_q = IN_TEXT;
  endtask

  task automatic code_complete(input logic [15:0] v);
    hex_acc = '0;
    digit_cnt = '0;
    if (v >= 16'hD800 && v <= 16'hDBFF) begin
      held_hi = v[9:0];
      phase_q = HIGH_HELD;
    end else begin
      emit_code_point({5'b0, v});
      phase_q = IN_TEXT;
    end
  endtask

  task automatic hex_digit(input logic [7:0] c, input bit held);
    int          d;
    logic [15:0] v;
    d = hex_nibble(c);
    if (d < 0) begin
      if (held) release_held();
      report_error(ST_BAD_UNI);
      return;
    end
    v = {hex_acc[11:0], d[3:0]};
    if (digit_cnt < 2'd3) begin
      hex_acc = v;
      digit_cnt = digit_cnt + 2'd1;
      return;
    end
    if (held) begin
      if (v >= 16'hDC00 && v <= 16'hDFFF) begin
        // Surrogate pair: ten bits from each half above the first plane.
        emit_code_point(21'h10000 + {1'b0, held_hi, v[9:0]});
        return_idle();
        phase_q = IN_TEXT;
        return;
      end
      release_held();
    end
    code_complete(v);
  endtask

  task automatic decode_transaction(input logic mode, input logic [7:0] c);
    step_q.delete();
    if (mode) begin
      case (phase_q)
        WAIT_QUOTE: report_error(ST_EXP_QUOTE);
        UNI_DIGITS: report_error(ST_BAD_UNI);
        HIGH_DIGITS: begin
          release_held();
          report_error(ST_BAD_UNI);
        end
        HIGH_HELD, HIGH_BSL: begin
          release_held();
          report_error(ST_UNTERM);
        end
        default: report_error(ST_UNTERM);
      endcase
    end else begin
      case (phase_q)
        WAIT_QUOTE: begin
          if (c == CH_QUOTE) phase_q = IN_TEXT;
          else emit(8'h00, ST_EXP_QUOTE);
        end
        IN_TEXT: text_byte(c);
        AFTER_BSL: escape_letter(c);
        UNI_DIGITS: hex_digit(c, 1'b0);
        HIGH_HELD: begin
          if (c == CH_BSL) begin
            phase_q = HIGH_BSL;
          end else begin
            release_held();
            text_byte(c);
          end
        end
        HIGH_BSL: begin
          if (c == "u") begin
            hex_acc = '0;
            digit_cnt = '0;
            phase_q = HIGH_DIGITS;
          end else begin
            release_held();
            escape_letter(c);
          end
        end
        HIGH_DIGITS: hex_digit(c, 1'b1);
        default: return_idle();
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) due_q.push_back(step_q[i]);
  endtask

  task automatic note_failure(input string what, input utf8_result_t want);
    fail_n++;
    if (fail_n <= ReportLimit) begin
      $display("%0t: %s: expected byte %02h status %0d last %0d",
               $realtime, what, want.data, want.status, want.last);
      $display("%0t: %s: got byte %02h status %0d last %0d",
               $realtime, what, out_byte, out_status, out_last);
    end
  endtask

  // Results are compared before the input of the same edge is decoded: a
  // result leaves the block at the earliest in the cycle after its cause.
  always @(posedge clk) begin
    utf8_result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        result_n++;
        if (out_status == ST_DONE) closed_n++;
        if (out_status >= ST_EXP_QUOTE) error_n++;
        if (due_q.size() == 0) begin
          note_failure("result with nothing due", '0);
        end else begin
          want = due_q.pop_front();
          if (out_byte !== want.data || out_status !== want.status ||
              out_last !== want.last) begin
            note_failure("result mismatch", want);
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        item_n++;
        decode_transaction(in_mode, in_byte);
      end
    end
    items_seen <= item_n;
    results_seen <= result_n;
    strings_closed <= closed_n;
    errors_seen <= error_n;
    outstanding <= due_q.size();
    failures <= fail_n;
  end

endmodule

// ===== tb/json_string_unescape_utf8_test.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Feeds the unescaper with directed and random JSON strings, escapes and
// broken input under random idling on both channels; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_string_unescape_utf8_test;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  // Least number of random input transactions after the directed part.
  localparam int RandomItems = 335;
  // Cycles allowed after the last result for a transaction with no result.
  localparam int SettleCycles = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_status;
  logic       out_last;

  int items_seen, results_seen, strings_closed, errors_seen, outstanding, failures;

  // Sender and receiver pacing state. The receiver's long hold is asked for
  // by the stimulus and counted down in the receiver's own process.
  int sent_n = 0;
  int send_steady = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int stall_left = 0;
  int recv_steady = 0;

  json_string_unescape_utf8 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_status(out_status),
    .out_last  (out_last)
  );

  json_string_unescape_utf8_check checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_status    (out_status),
    .out_last      (out_last),
    .items_seen    (items_seen),
    .results_seen  (results_seen),
    .strings_closed(strings_closed),
    .errors_seen   (errors_seen),
    .outstanding   (outstanding),
    .failures      (failures)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver. Mostly it takes results at once, otherwise it stalls, now and
  // then for a long stretch. Steady stretches with no stall at all are mixed
  // in, and a requested long hold takes priority so that the result buffer
  // fills and the block stalls its input.
  always @(posedge clk) begin
    int pick;
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      stall_left = 90;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (recv_steady > 0) begin
      out_stall <= 1'b0;
      recv_steady--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        recv_steady = $urandom_range(10, 60);
        out_stall <= 1'b0;
      end else if (pick < 70) begin
        out_stall <= 1'b0;
      end else if (pick < 96) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(6, 30);
        out_stall <= 1'b1;
      end
    end
  end

  // Idle cycles before the next input transaction: usually none, often a
  // short gap, rarely a long one, with steady stretches of back-to-back
  // transactions.
  function automatic int pick_gap();
    int pick;
    if (send_steady > 0) begin
      send_steady--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send_steady = $urandom_range(10, 50);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Offers one input transaction and returns at the edge that accepts it.
  // The valid stays high into the next call unless a gap is chosen there.
  task automatic push_item(input logic mode, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    sent_n++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item(1'b0, b);
  endtask

  // The byte field is don't-care with an end mark, so it carries noise.
  task automatic send_end();
    push_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSL || c == "/" || c == "b" || c == "f" ||
           c == "n" || c == "r" || c == "t" || c == "u";
  endfunction

  // Sends the first 'digits' hex digits of a \u escape for value v.
  task automatic send_uni_digits(input logic [15:0] v, input int digits);
    send_byte(CH_BSL);
    send_byte("u");
    for (int i = 0; i < digits; i++) send_byte(hex_char(v[15 - 4 * i -: 4]));
  endtask

  task automatic send_uni(input logic [15:0] v);
    send_uni_digits(v, 4);
  endtask

  function automatic logic [15:0] plain_code_point();
    logic [15:0] v;
    case ($urandom_range(0, 2))
      0: v = 16'($urandom_range(16'h0000, 16'h007F));
      1: v = 16'($urandom_range(16'h0080, 16'h07FF));
      default: begin
        do v = 16'($urandom_range(16'h0800, 16'hFFFF));
        while (v >= 16'hD800 && v <= 16'hDFFF);
      end
    endcase
    return v;
  endfunction

  function automatic logic [15:0] high_half();
    return 16'hD800 + 16'($urandom_range(0, 1023));
  endfunction

  function automatic logic [15:0] low_half();
    return 16'hDC00 + 16'($urandom_range(0, 1023));
  endfunction

  // One string with random content. Most strings close properly; the rest
  // end in the middle, in a broken escape or with a held high surrogate.
  task automatic send_random_string();
    int          pick;
    logic [7:0]  b;
    send_byte(CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Raw bytes pass straight through, NUL and non-ASCII included.
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSL);
        send_byte(b);
      end else if (pick < 65) begin
        do b = 8'($urandom_range(0, 255)); while (!is_escape_letter(b) || b == "u");
        send_byte(CH_BSL);
        send_byte(b);
      end else if (pick < 80) begin
        send_uni(plain_code_point());
      end else if (pick < 90) begin
        send_uni(high_half());
        send_uni(low_half());
      end else if (pick < 95) begin
        // A high half left open; whatever part comes next must flush it.
        send_uni(high_half());
      end else begin
        send_uni(low_half());
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      send_byte(CH_QUOTE);
    end else if (pick < 82) begin
      send_end();
    end else if (pick < 86) begin
      do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
      send_byte(CH_BSL);
      send_byte(b);
    end else if (pick < 90) begin
      do b = 8'($urandom_range(0, 255)); while (is_hex_char(b));
      send_uni_digits(plain_code_point(), $urandom_range(0, 3));
      send_byte(b);
    end else if (pick < 93) begin
      send_uni_digits(plain_code_point(), $urandom_range(0, 3));
      send_end();
    end else if (pick < 96) begin
      send_uni(high_half());
      if ($urandom_range(0, 1)) send_byte(CH_BSL);
      send_end();
    end else begin
      // A second \u after a high half that breaks off or is cut short.
      send_uni(high_half());
      send_uni_digits(low_half(), $urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
        send_end();
      end else begin
        do b = 8'($urandom_range(0, 255)); while (is_hex_char(b));
        send_byte(b);
      end
    end
  endtask

  // Stops offering input until every predicted result has been taken, then
  // waits SettleCycles more for a transaction that produced no result at all.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    int  random_start;
    bit  hold_done;
    bit  pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. An end mark and a stray byte while waiting for a quote.
    send_end();
    send_byte(8'h7B);
    // NUL and 0xFF pass through, then an unknown escape letter.
    send_byte(CH_QUOTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_BSL);
    send_byte("q");
    // A high surrogate held, then a non-hex byte: its three bytes, then that
    // byte as plain string content.
    send_byte(CH_QUOTE);
    send_byte(CH_BSL);
    send_byte("u");
    send_byte("D");
    send_byte("8");
    send_byte("0");
    send_byte("0");
    send_byte("x");
    // The quote closes that string, so the escape bytes and end mark each report an expected quote.
    send_byte(CH_QUOTE);
    send_byte(CH_BSL);
    send_byte("u");
    send_byte("F");
    send_end();
    // End of text inside plain string content.
    send_byte(CH_QUOTE);
    send_end();
    // A high surrogate followed by a plain character instead of a low half.
    send_byte(CH_QUOTE);
    send_byte(CH_BSL);
    send_byte("u");
    send_byte("d");
    send_byte("b");
    send_byte("f");
    send_byte("f");
    send_byte("A");
    send_byte(CH_QUOTE);

    // Random part: mostly whole strings, with a little noise between them.
    random_start = sent_n;
    while (sent_n < random_start + RandomItems) begin
      if (!hold_done && sent_n >= random_start + 120) begin
        // The receiver holds off for a long stretch while transactions keep
        // coming back to back, so the buffer fills and the input stalls.
        hold_done = 1'b1;
        send_steady = 150;
        holds_asked++;
      end
      if (!pause_done && sent_n >= random_start + 250) begin
        pause_done = 1'b1;
        drain();
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          send_end();
        end else begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)) & 8'hFD);
        end
      end
      send_random_string();
    end

    drain();
    $display("Run covered %0d input transactions and %0d results.", items_seen, results_seen);
    $display("Results included %0d closed strings and %0d error reports.",
             strings_closed, errors_seen);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
